// ----- rtl/i2p_pkg.sv -----
package i2p_pkg;

  // ASCII characters the converter reacts to.
  localparam logic [7:0] CH_LPAR    = 8'h28;
  localparam logic [7:0] CH_RPAR    = 8'h29;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_UNKNOWN = 8'h3F;

  typedef logic [2:0] op_code_t;

  localparam op_code_t OP_LPAR  = 3'd0;
  localparam op_code_t OP_PLUS  = 3'd1;
  localparam op_code_t OP_MINUS = 3'd2;
  localparam op_code_t OP_MUL   = 3'd3;
  localparam op_code_t OP_DIV   = 3'd4;
  localparam op_code_t OP_MOD   = 3'd5;
  localparam op_code_t OP_POW   = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OPND,
    ST_POP_RD,
    ST_POP_CHK,
    ST_POP_SP,
    ST_FL_SP,
    ST_FL_OP,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    EL_NONE,
    EL_CHAR,
    EL_TOP,
    EL_SPACE,
    EL_NEWLINE
  } elem_sel_t;

  typedef struct packed {
    logic      load;
    elem_sel_t elem;
    logic      pop;
    logic      end_op;
    logic      finish;
  } cmd_t;

  typedef struct packed {
    logic in_is_op;
    logic last;
    logic stop;
    logic cnt_zero;
    logic stall;
  } sts_t;

  function automatic logic is_op(input logic [7:0] ch);
    logic r;
    case (ch)
      CH_LPAR, CH_RPAR, CH_PLUS, CH_MINUS, CH_STAR,
      CH_SLASH, CH_PERCENT, CH_CARET: r = 1'b1;
      default:                        r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic op_code_t op_code(input logic [7:0] ch);
    op_code_t r;
    case (ch)
      CH_PLUS:    r = OP_PLUS;
      CH_MINUS:   r = OP_MINUS;
      CH_STAR:    r = OP_MUL;
      CH_SLASH:   r = OP_DIV;
      CH_PERCENT: r = OP_MOD;
      CH_CARET:   r = OP_POW;
      default:    r = OP_LPAR;
    endcase
    return r;
  endfunction

  // A set bit marks a stacked operator code that ends the popping run.
  // Open parenthesis and caret stop at once, so they only push.
  function automatic logic [7:0] stop_mask(input logic [7:0] ch);
    logic [7:0] r;
    case (ch)
      CH_RPAR, CH_PLUS, CH_MINUS: r = 8'b0000_0001;
      CH_STAR:                    r = 8'b0000_0111;
      CH_SLASH, CH_PERCENT:       r = 8'b0000_1111;
      default:                    r = 8'b1111_1111;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] code_char(input op_code_t code);
    logic [7:0] r;
    case (code)
      OP_LPAR:  r = CH_LPAR;
      OP_PLUS:  r = CH_PLUS;
      OP_MINUS: r = CH_MINUS;
      OP_MUL:   r = CH_STAR;
      OP_DIV:   r = CH_SLASH;
      OP_MOD:   r = CH_PERCENT;
      OP_POW:   r = CH_CARET;
      default:  r = CH_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/infix_to_postfix_converter.sv -----
// Operand request: ST_OPND and ST_FIN lie between acceptance and the next free input slot.
// Operator request: ST_POP_RD, ST_POP_CHK and ST_FIN, plus ST_POP_CHK and ST_POP_SP per
// operator popped, since the stack memory has one registered read port and each pop emits
// two characters. A final request adds ST_FL_SP and ST_FL_OP per flushed operator and
// ST_FL_SP for the newline. The last result of a request moves into the output register in ST_FIN.
// Reset clears the stack count, space filter and overflow flag; stack memory is not cleared.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_char
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_char
  output logic       out_tlast,
  output logic       out_tuser   // [0] overflow_seen
);

  i2p_pkg::cmd_t cmd;
  i2p_pkg::sts_t sts;

  i2p_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  i2p_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- rtl/i2p_ctrl.sv -----
module i2p_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  i2p_pkg::sts_t sts,
  output i2p_pkg::cmd_t cmd
);

  i2p_pkg::state_t state_r;
  i2p_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2p_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      i2p_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sts.in_is_op ? i2p_pkg::ST_POP_RD : i2p_pkg::ST_OPND;
        end
      end
      i2p_pkg::ST_OPND: begin
        if (!sts.stall) begin
          state_nxt = sts.last ? i2p_pkg::ST_FL_SP : i2p_pkg::ST_FIN;
        end
      end
      i2p_pkg::ST_POP_RD: begin
        state_nxt = i2p_pkg::ST_POP_CHK;
      end
      i2p_pkg::ST_POP_CHK: begin
        if (sts.stop) begin
          state_nxt = sts.last ? i2p_pkg::ST_FL_SP : i2p_pkg::ST_FIN;
        end else if (!sts.stall) begin
          state_nxt = i2p_pkg::ST_POP_SP;
        end
      end
      i2p_pkg::ST_POP_SP: begin
        if (!sts.stall) begin
          state_nxt = i2p_pkg::ST_POP_CHK;
        end
      end
      i2p_pkg::ST_FL_SP: begin
        if (!sts.stall) begin
          state_nxt = sts.cnt_zero ? i2p_pkg::ST_FIN : i2p_pkg::ST_FL_OP;
        end
      end
      i2p_pkg::ST_FL_OP: begin
        if (!sts.stall) begin
          state_nxt = i2p_pkg::ST_FL_SP;
        end
      end
      i2p_pkg::ST_FIN: begin
        if (!sts.stall) begin
          state_nxt = i2p_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = i2p_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd.load   = 1'b0;
    cmd.elem   = i2p_pkg::EL_NONE;
    cmd.pop    = 1'b0;
    cmd.end_op = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      i2p_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      i2p_pkg::ST_OPND: begin
        cmd.elem = i2p_pkg::EL_CHAR;
      end
      i2p_pkg::ST_POP_RD: begin
      end
      i2p_pkg::ST_POP_CHK: begin
        if (sts.stop) begin
          cmd.end_op = 1'b1;
        end else begin
          cmd.elem = i2p_pkg::EL_TOP;
          cmd.pop  = 1'b1;
        end
      end
      i2p_pkg::ST_POP_SP: begin
        cmd.elem = i2p_pkg::EL_SPACE;
      end
      i2p_pkg::ST_FL_SP: begin
        cmd.elem = sts.cnt_zero ? i2p_pkg::EL_NEWLINE : i2p_pkg::EL_SPACE;
      end
      i2p_pkg::ST_FL_OP: begin
        cmd.elem = i2p_pkg::EL_TOP;
        cmd.pop  = 1'b1;
      end
      i2p_pkg::ST_FIN: begin
        cmd.finish = 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/i2p_dp.sv -----
module i2p_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  input  i2p_pkg::cmd_t cmd,
  output i2p_pkg::sts_t sts,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast,
  output logic          out_tuser
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  i2p_pkg::op_code_t mem [STACK_DEPTH];
  i2p_pkg::op_code_t rd_r;

  logic [7:0]   cur_char_r;
  logic         cur_last_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic         first_r, first_nxt;
  logic         srun_r, srun_nxt;
  logic         ovf_r, ovf_nxt;
  logic         hold_v_r, hold_v_nxt;
  logic [7:0]   hold_char_r;
  logic         hold_ovf_r;
  logic         out_v_r, out_v_nxt;
  logic [7:0]   out_char_r;
  logic         out_last_r;
  logic         out_ovf_r;

  i2p_pkg::op_code_t cur_code;
  logic [7:0]   mask;
  logic         is_close;
  logic         cnt_zero;
  logic         full;
  logic [7:0]   ch;
  logic         pass;
  logic         out_free;
  logic         need_out;
  logic         stall;
  logic         go;
  logic         push_en;
  logic         shift_out;
  logic         final_out;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] cnt_m1;

  assign cur_code = i2p_pkg::op_code(cur_char_r);
  assign mask     = i2p_pkg::stop_mask(cur_char_r);
  assign is_close = (cur_char_r == i2p_pkg::CH_RPAR);
  assign cnt_zero = (cnt_r == '0);
  assign full     = (cnt_r == CW'(STACK_DEPTH));
  assign cnt_m1   = cnt_r - CW'(1);
  assign rd_addr  = cnt_m1[AW-1:0];

  always_comb begin
    case (cmd.elem)
      i2p_pkg::EL_CHAR:    ch = cur_char_r;
      i2p_pkg::EL_TOP:     ch = i2p_pkg::code_char(rd_r);
      i2p_pkg::EL_SPACE:   ch = i2p_pkg::CH_SPACE;
      i2p_pkg::EL_NEWLINE: ch = i2p_pkg::CH_NEWLINE;
      default:             ch = i2p_pkg::CH_SPACE;
    endcase
  end

  // A space is dropped when it is the first element of an expression and right after
  // another output space; the newline always goes out.
  assign pass = (cmd.elem != i2p_pkg::EL_NONE) &&
                ((cmd.elem == i2p_pkg::EL_NEWLINE) ||
                 !((ch == i2p_pkg::CH_SPACE) && (first_r || srun_r)));

  // The newest element waits in the hold stage until the next one shows
  // whether it is the last of its request.
  assign out_free  = !out_v_r || out_tready;
  assign need_out  = (pass || cmd.finish) && hold_v_r;
  assign stall     = need_out && !out_free;
  assign go        = !stall;
  assign push_en   = go && cmd.end_op && !is_close && !full;
  assign shift_out = go && pass && hold_v_r;
  assign final_out = go && cmd.finish && hold_v_r;

  assign sts.in_is_op = i2p_pkg::is_op(in_tdata);
  assign sts.last     = cur_last_r;
  assign sts.stop     = cnt_zero || mask[rd_r];
  assign sts.cnt_zero = cnt_zero;
  assign sts.stall    = stall;

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[cnt_r[AW-1:0]] <= cur_code;
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_char_r <= in_tdata;
      cur_last_r <= in_tlast;
    end
    if (go && pass) begin
      hold_char_r <= ch;
      hold_ovf_r  <= (cmd.elem == i2p_pkg::EL_NEWLINE) ? ovf_r : 1'b0;
    end
    if (shift_out || final_out) begin
      out_char_r <= hold_char_r;
      out_ovf_r  <= hold_ovf_r;
      out_last_r <= final_out;
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    first_nxt  = first_r;
    srun_nxt   = srun_r;
    ovf_nxt    = ovf_r;
    hold_v_nxt = hold_v_r;
    out_v_nxt  = out_v_r && !out_tready;

    if (go) begin
      if (cmd.pop) begin
        cnt_nxt = cnt_m1;
      end
      if (cmd.end_op) begin
        if (is_close) begin
          if (!cnt_zero) begin
            cnt_nxt = cnt_m1;
          end
        end else if (full) begin
          ovf_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      if (cmd.elem == i2p_pkg::EL_NEWLINE) begin
        first_nxt = 1'b1;
        srun_nxt  = 1'b0;
        ovf_nxt   = 1'b0;
      end else if (cmd.elem != i2p_pkg::EL_NONE) begin
        if (ch == i2p_pkg::CH_SPACE) begin
          if (first_r) begin
            first_nxt = 1'b0;
          end else begin
            srun_nxt = 1'b1;
          end
        end else begin
          first_nxt = 1'b0;
          srun_nxt  = 1'b0;
        end
      end
      if (pass) begin
        hold_v_nxt = 1'b1;
      end else if (final_out) begin
        hold_v_nxt = 1'b0;
      end
    end
    if (shift_out || final_out) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      first_r  <= 1'b1;
      srun_r   <= 1'b0;
      ovf_r    <= 1'b0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      first_r  <= first_nxt;
      srun_r   <= srun_nxt;
      ovf_r    <= ovf_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  localparam int STACK_DEPTH = 16;
  localparam int PHASE_ITEMS = 16;

  typedef struct {
    logic [7:0] ch;
    logic       tail;
    logic       ovf;
  } postfix_char_t;

  // Predicts the postfix character stream and checks the converter against it.
  class postfix_scoreboard;
    i2p_pkg::op_code_t ops [STACK_DEPTH];
    int                depth;
    bit                at_start;
    bit                after_space;
    bit                push_dropped;
    postfix_char_t     due [$];
    postfix_char_t     batch [$];
    int                errors;

    function new();
      depth        = 0;
      at_start     = 1'b1;
      after_space  = 1'b0;
      push_dropped = 1'b0;
      errors       = 0;
    endfunction

    function logic [7:0] glyph(i2p_pkg::op_code_t code);
      case (code)
        i2p_pkg::OP_LPAR:  return i2p_pkg::CH_LPAR;
        i2p_pkg::OP_PLUS:  return i2p_pkg::CH_PLUS;
        i2p_pkg::OP_MINUS: return i2p_pkg::CH_MINUS;
        i2p_pkg::OP_MUL:   return i2p_pkg::CH_STAR;
        i2p_pkg::OP_DIV:   return i2p_pkg::CH_SLASH;
        i2p_pkg::OP_MOD:   return i2p_pkg::CH_PERCENT;
        i2p_pkg::OP_POW:   return i2p_pkg::CH_CARET;
        default:           return i2p_pkg::CH_UNKNOWN;
      endcase
    endfunction

    // Precedence is lopsided on purpose: a star does not get popped by a slash.
    function bit popped_by(logic [7:0] ch, i2p_pkg::op_code_t top);
      case (ch)
        i2p_pkg::CH_RPAR, i2p_pkg::CH_PLUS, i2p_pkg::CH_MINUS:
          return top != i2p_pkg::OP_LPAR;
        i2p_pkg::CH_STAR:
          return top inside {i2p_pkg::OP_MUL, i2p_pkg::OP_DIV,
                             i2p_pkg::OP_MOD, i2p_pkg::OP_POW};
        i2p_pkg::CH_SLASH, i2p_pkg::CH_PERCENT:
          return top inside {i2p_pkg::OP_DIV, i2p_pkg::OP_MOD, i2p_pkg::OP_POW};
        default:
          return 1'b0;
      endcase
    endfunction

    function void put(logic [7:0] ch, logic ovf);
      postfix_char_t e;
      e.ch   = ch;
      e.tail = 1'b0;
      e.ovf  = ovf;
      batch.push_back(e);
    endfunction

    function void put_filtered(logic [7:0] ch);
      if (ch == i2p_pkg::CH_SPACE) begin
        if (at_start) begin
          at_start = 1'b0;
        end else if (!after_space) begin
          after_space = 1'b1;
          put(ch, 1'b0);
        end
      end else begin
        at_start    = 1'b0;
        after_space = 1'b0;
        put(ch, 1'b0);
      end
    endfunction

    function void push(i2p_pkg::op_code_t code);
      if (depth >= STACK_DEPTH) begin
        push_dropped = 1'b1;
      end else begin
        ops[depth] = code;
        depth      = depth + 1;
      end
    endfunction

    function void pop_run(logic [7:0] ch);
      while (depth > 0 && popped_by(ch, ops[depth-1])) begin
        depth = depth - 1;
        put_filtered(glyph(ops[depth]));
        put_filtered(i2p_pkg::CH_SPACE);
      end
    endfunction

    function void note_request(logic [7:0] ch, logic is_last);
      batch.delete();
      case (ch)
        i2p_pkg::CH_LPAR: push(i2p_pkg::OP_LPAR);
        i2p_pkg::CH_RPAR: begin
          pop_run(ch);
          if (depth > 0) depth = depth - 1;
        end
        i2p_pkg::CH_PLUS, i2p_pkg::CH_MINUS: begin
          pop_run(ch);
          push(ch == i2p_pkg::CH_PLUS ? i2p_pkg::OP_PLUS : i2p_pkg::OP_MINUS);
        end
        i2p_pkg::CH_STAR: begin
          pop_run(ch);
          push(i2p_pkg::OP_MUL);
        end
        i2p_pkg::CH_SLASH, i2p_pkg::CH_PERCENT: begin
          pop_run(ch);
          push(ch == i2p_pkg::CH_SLASH ? i2p_pkg::OP_DIV : i2p_pkg::OP_MOD);
        end
        i2p_pkg::CH_CARET: push(i2p_pkg::OP_POW);
        default:           put_filtered(ch);
      endcase
      if (is_last) begin
        while (depth > 0) begin
          depth = depth - 1;
          put_filtered(i2p_pkg::CH_SPACE);
          put_filtered(glyph(ops[depth]));
        end
        put(i2p_pkg::CH_NEWLINE, push_dropped);
        at_start     = 1'b1;
        after_space  = 1'b0;
        push_dropped = 1'b0;
      end
      if (batch.size() > 0) batch[batch.size()-1].tail = 1'b1;
      foreach (batch[i]) due.push_back(batch[i]);
    endfunction

    function void check_result(logic [7:0] ch, logic tail, logic ovf);
      postfix_char_t want;
      if (due.size() == 0) begin
        errors++;
        $error("unexpected result: out_char %02h", ch);
        return;
      end
      want = due.pop_front();
      if (ch !== want.ch) begin
        errors++;
        $error("out_char mismatch: expected %02h, actual %02h", want.ch, ch);
      end
      if (tail !== want.tail) begin
        errors++;
        $error("run_last mismatch: expected %0b, actual %0b", want.tail, tail);
      end
      if (ovf !== want.ovf) begin
        errors++;
        $error("overflow_seen mismatch: expected %0b, actual %0b", want.ovf, ovf);
      end
    endfunction

    function void finish_check();
      if (due.size() != 0) begin
        errors++;
        $error("%0d expected results never arrived", due.size());
      end
    endfunction
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] in_char
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] out_char
  logic       out_tlast;
  logic       out_tuser;           // [0] overflow_seen

  postfix_scoreboard sb = new();

  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int hold_req      = 0;
  int hold_tag      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int sent          = 0;

  infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver side; a requested hold-off is counted down here.
  always @(negedge clk) begin
    if (hold_tag != hold_seen) begin
      hold_seen = hold_tag;
      hold_left = hold_req;
    end
    if (hold_left > 0) begin
      hold_left  = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_char(input logic [7:0] ch, input logic is_last);
    if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= is_last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(ch, is_last);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_seq(input logic [7:0] seq [$]);
    foreach (seq[i]) send_char(seq[i], i == seq.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] seq [$];
    for (int i = 0; i < s.len(); i++) seq.push_back(s[i]);
    send_seq(seq);
  endtask

  function automatic logic [7:0] random_operator();
    case ($urandom_range(5))
      0:       return i2p_pkg::CH_PLUS;
      1:       return i2p_pkg::CH_MINUS;
      2:       return i2p_pkg::CH_STAR;
      3:       return i2p_pkg::CH_SLASH;
      4:       return i2p_pkg::CH_PERCENT;
      default: return i2p_pkg::CH_CARET;
    endcase
  endfunction

  function automatic logic [7:0] operand_char();
    case ($urandom_range(7))
      0:       return 8'($urandom_range(255));
      1, 2:    return 8'h30 + 8'($urandom_range(9));
      default: return 8'h61 + 8'($urandom_range(25));
    endcase
  endfunction

  task automatic send_formula();
    logic [7:0] seq [$];
    int         opens;
    int         n;
    opens = 0;
    n     = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      while (opens < 3 && $urandom_range(3) == 0) begin
        seq.push_back(i2p_pkg::CH_LPAR);
        opens++;
      end
      if ($urandom_range(7) == 0) seq.push_back(i2p_pkg::CH_SPACE);
      seq.push_back(operand_char());
      if ($urandom_range(7) == 0) seq.push_back(i2p_pkg::CH_SPACE);
      while (opens > 0 && $urandom_range(2) == 0) begin
        seq.push_back(i2p_pkg::CH_RPAR);
        opens--;
      end
      if (i < n - 1) seq.push_back(random_operator());
    end
    while (opens > 0) begin
      seq.push_back(i2p_pkg::CH_RPAR);
      opens--;
    end
    send_seq(seq);
  endtask

  // Pushes without popping so that the stack runs near or past its depth.
  task automatic send_deep();
    logic [7:0] seq [$];
    int         n;
    n = $urandom_range(12, 22);
    for (int i = 0; i < n; i++) begin
      seq.push_back($urandom_range(1) ? i2p_pkg::CH_LPAR : i2p_pkg::CH_CARET);
      if ($urandom_range(2) == 0) seq.push_back(operand_char());
    end
    seq.push_back(operand_char());
    send_seq(seq);
  endtask

  task automatic send_noise();
    logic [7:0] seq [$];
    int         n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0:       seq.push_back($urandom_range(1) ? i2p_pkg::CH_LPAR : i2p_pkg::CH_RPAR);
        1:       seq.push_back($urandom_range(1) ? i2p_pkg::CH_SPACE : random_operator());
        default: seq.push_back(8'($urandom_range(255)));
      endcase
    end
    send_seq(seq);
  endtask

  task automatic send_random(input int count);
    int start;
    int pick;
    start = sent;
    while (sent - start < count) begin
      pick = $urandom_range(99);
      if (pick < 70) send_formula();
      else if (pick < 85) send_deep();
      else send_noise();
    end
  endtask

  task automatic drain();
    while (sb.due.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Leading spaces, all six operators, an unmatched close parenthesis, the byte
    // extremes and a lone operator as a whole expression.
    send_text("  a+b*c");
    send_text("(d-e)/f%g^h)");
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(i2p_pkg::CH_CARET, 1'b1);
    in_tvalid <= 1'b0;
    drain();

    // Long receiver hold-off while the sender keeps offering requests.
    hold_req = 200;
    hold_tag++;
    send_deep();
    send_formula();
    send_random(PHASE_ITEMS);
    in_tvalid <= 1'b0;
    drain();

    in_idle_pct   = 50;
    out_stall_pct = 0;
    send_random(PHASE_ITEMS);
    in_tvalid <= 1'b0;
    drain();

    in_idle_pct   = 0;
    out_stall_pct = 50;
    send_random(PHASE_ITEMS);
    in_tvalid <= 1'b0;
    drain();

    in_idle_pct   = 37;
    out_stall_pct = 37;
    send_random(PHASE_ITEMS);
    in_tvalid <= 1'b0;
    drain();

    repeat (60) @(negedge clk);
    sb.finish_check();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
